[sv/table_driven_random_draw_top_assert.svh]
// Assertion macros shared by the draw unit's modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TABLE_DRIVEN_RANDOM_DRAW_TOP_ASSERT_SVH
`define TABLE_DRIVEN_RANDOM_DRAW_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tdrd_pkg.sv]
package tdrd_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // The position can run two past the last entry after a skip.
    localparam int POS_W       = $clog2(TABLE_DEPTH + 3);
    localparam int WORD_W      = 32;
    localparam int LEN_W       = 9;
    localparam int IDX_W       = 8;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_CNT_W   = $clog2(WORD_W);
    localparam int IN_DATA_W   = IDX_W + WORD_W;

    localparam logic [WORD_W-1:0]    LOWER_RESET = 32'd0;
    localparam logic [WORD_W-1:0]    UPPER_RESET = 32'd65536;
    localparam logic [LEN_W-1:0]     LEN_RESET   = 9'd150;
    localparam logic [WORD_W-1:0]    SEED_RESET  = 32'd0;
    localparam logic [3:0]           NIBBLE_MASK = 4'hF;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(WORD_W - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_DRAW    = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER  = 2'd0,
        REG_UPPER  = 2'd1,
        REG_LENGTH = 2'd2,
        REG_SEED   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic latch_in;
        logic do_load;
        logic do_restart;
        logic do_advance;
        logic do_accum;
        logic do_adjust;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } dp_stat_t;

endpackage

[sv/tdrd_ram.sv]
module tdrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/tdrd_ctrl.sv]
module tdrd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  tdrd_pkg::dp_stat_t  stat,
    output tdrd_pkg::dp_cmd_t   cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_FETCH  = 6'b000100,
        S_ADJUST = 6'b001000,
        S_DIV    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [tdrd_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.cmd)
                    tdrd_pkg::CMD_LOAD:
                    begin
                        cmd.do_load = 1'b1;
                        state_next  = S_DONE;
                    end
                    tdrd_pkg::CMD_DRAW:
                    begin
                        cmd.do_advance = 1'b1;
                        state_next     = S_FETCH;
                    end
                    tdrd_pkg::CMD_RESTART:
                    begin
                        cmd.do_restart = 1'b1;
                        state_next     = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FETCH:
            begin
                cmd.do_accum = 1'b1;
                state_next   = S_ADJUST;
            end
            S_ADJUST:
            begin
                cmd.do_adjust = 1'b1;
                cnt_next      = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == tdrd_pkg::DIV_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;

`include "table_driven_random_draw_top_assert.svh"

    `TDRD_ASSERT_NEXT(accept_starts_exec, s_axis_tvalid && s_axis_tready, state_reg == S_EXEC, "accepted beat did not start execution")
    `TDRD_ASSERT_NOW(div_runs_full_width, state_reg == S_DONE && $past(state_reg) == S_DIV, $past(cnt_reg) == tdrd_pkg::DIV_LAST, "remainder finished early")
    `TDRD_ASSERT_NOW(result_not_overwritten, out_valid_reg && !m_axis_tready, !cmd.out_load, "waiting result overwritten")

endmodule

[sv/tdrd_dp.sv]
module tdrd_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [tdrd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdrd_pkg::WORD_W-1:0]         cfg_data,
    input  logic [tdrd_pkg::IN_DATA_W-1:0]      in_data,
    input  logic [tdrd_pkg::CMD_W-1:0]          in_user,
    input  tdrd_pkg::dp_cmd_t                   cmd,
    output tdrd_pkg::dp_stat_t                  stat,
    output logic [tdrd_pkg::WORD_W-1:0]         out_value,
    output logic                                out_error
);

    localparam int W  = tdrd_pkg::WORD_W;
    localparam int PW = tdrd_pkg::POS_W;

    // Configuration registers.
    logic [W-1:0]               lower_reg, lower_next;
    logic [W-1:0]               upper_reg, upper_next;
    logic [tdrd_pkg::LEN_W-1:0] length_reg, length_next;
    logic [W-1:0]               init_seed_reg, init_seed_next;

    // Latched input beat.
    tdrd_pkg::cmd_t             cmd_reg;
    logic [tdrd_pkg::IDX_W-1:0] idx_reg;
    logic [W-1:0]               value_reg;

    // Generator state and remainder unit.
    logic [W-1:0]  seed_reg, seed_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [W-1:0]  span_reg;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W-1:0]  out_value_reg;
    logic          out_error_reg;

    logic [PW-1:0]                  len_eff;
    logic [PW:0]                    pos_inc;
    logic [PW-1:0]                  pos_adv;
    logic [W-1:0]                   rd_data;
    logic                           idx_ok;
    logic [W-1:0]                   wr_word;
    logic                           nibble_nz;
    logic [W-1:0]                   seed_adj;
    logic [W:0]                     trial;
    logic [W:0]                     diff;

    // Table length above the depth saturates at the depth.
    always_comb
    begin
        if (W'(length_reg) > W'(tdrd_pkg::TABLE_DEPTH))
        begin
            len_eff = PW'(tdrd_pkg::TABLE_DEPTH);
        end
        else
        begin
            len_eff = PW'(length_reg);
        end
    end

    assign pos_inc   = {1'b0, pos_reg} + (PW+1)'(1);
    assign pos_adv   = (pos_inc >= {1'b0, len_eff}) ? '0 : pos_inc[PW-1:0];
    assign idx_ok    = (W'(idx_reg) < W'(tdrd_pkg::TABLE_DEPTH));
    assign wr_word   = (value_reg == '0) ? W'(1) : value_reg;
    assign nibble_nz = |(seed_reg[3:0] & tdrd_pkg::NIBBLE_MASK);
    assign seed_adj  = nibble_nz ? (seed_reg + W'(1)) : seed_reg;
    assign trial     = {rem_reg, dvd_reg[W-1]};
    assign diff      = trial - {1'b0, span_reg};

    tdrd_ram #(
        .WIDTH (W),
        .DEPTH (tdrd_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.do_load && idx_ok),
        .wr_addr (tdrd_pkg::ADDR_W'(idx_reg)),
        .wr_data (wr_word),
        .rd_en   (cmd.do_advance),
        .rd_addr (tdrd_pkg::ADDR_W'(pos_adv)),
        .rd_data (rd_data)
    );

    always_comb
    begin
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        length_next    = length_reg;
        init_seed_next = init_seed_reg;
        if (cfg_wr_en)
        begin
            unique case (tdrd_pkg::cfg_reg_t'(cfg_index))
                tdrd_pkg::REG_LOWER:  lower_next     = cfg_data;
                tdrd_pkg::REG_UPPER:  upper_next     = cfg_data;
                tdrd_pkg::REG_LENGTH: length_next    = cfg_data[tdrd_pkg::LEN_W-1:0];
                tdrd_pkg::REG_SEED:   init_seed_next = cfg_data;
                default:              lower_next     = lower_reg;
            endcase
        end
    end

    always_comb
    begin
        seed_next = seed_reg;
        pos_next  = pos_reg;
        if (cmd.do_restart)
        begin
            seed_next = init_seed_reg;
            pos_next  = PW'(1);
        end
        else if (cmd.do_advance)
        begin
            pos_next = pos_adv;
        end
        else if (cmd.do_accum)
        begin
            seed_next = seed_reg + rd_data;
        end
        else if (cmd.do_adjust)
        begin
            seed_next = seed_adj;
            if (nibble_nz)
            begin
                pos_next = pos_reg + PW'(2);
            end
        end
    end

    // Restoring remainder, one dividend bit per step.
    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        if (cmd.do_adjust)
        begin
            rem_next = '0;
            dvd_next = seed_adj;
        end
        else if (cmd.div_step)
        begin
            rem_next = diff[W] ? trial[W-1:0] : diff[W-1:0];
            dvd_next = {dvd_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg     <= tdrd_pkg::LOWER_RESET;
            upper_reg     <= tdrd_pkg::UPPER_RESET;
            length_reg    <= tdrd_pkg::LEN_RESET;
            init_seed_reg <= tdrd_pkg::SEED_RESET;
            seed_reg      <= '0;
            pos_reg       <= PW'(1);
        end
        else
        begin
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            length_reg    <= length_next;
            init_seed_reg <= init_seed_next;
            seed_reg      <= seed_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg   <= tdrd_pkg::cmd_t'(in_user);
            idx_reg   <= in_data[tdrd_pkg::IDX_W-1:0];
            value_reg <= in_data[tdrd_pkg::IN_DATA_W-1:tdrd_pkg::IDX_W];
        end
        if (cmd.do_advance)
        begin
            span_reg <= upper_reg - lower_reg;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (cmd.out_load)
        begin
            if (cmd_reg != tdrd_pkg::CMD_DRAW)
            begin
                out_value_reg <= '0;
                out_error_reg <= 1'b0;
            end
            else if (span_reg == '0)
            begin
                out_value_reg <= lower_reg;
                out_error_reg <= 1'b1;
            end
            else
            begin
                out_value_reg <= rem_reg + lower_reg;
                out_error_reg <= 1'b0;
            end
        end
    end

    assign stat.cmd  = cmd_reg;
    assign out_value = out_value_reg;
    assign out_error = out_error_reg;

`include "table_driven_random_draw_top_assert.svh"

    `TDRD_ASSERT_NOW(pos_in_bounds, 1'b1, {1'b0, pos_reg} <= (PW+1)'(tdrd_pkg::TABLE_DEPTH + 1), "table position ran past its bound")
    `TDRD_ASSERT_NEXT(advance_below_length, cmd.do_advance, pos_reg == '0 || pos_reg < len_eff, "advanced position not below table length")

endmodule

[sv/table_driven_random_draw_top.sv]
// Table-driven random draw unit. Load beats (command 0) write one 32-bit word
// into a 256-entry table, storing a zero word as one; draw beats (command 1)
// step a position through the table, fold the addressed word into a running
// seed and return seed modulo (upper_bound - lower_bound) plus lower_bound,
// with range_error set and lower_bound returned when that span is zero;
// restart beats (command 2) reload the seed from initial_seed and set the
// position to 1. Every input beat yields exactly one result beat, and all
// but draw beats return zeros. The unit works on one beat at a time: a draw
// passes from acceptance through the table read, the seed add and the seed
// adjust, then the radix-2 remainder unit, which resolves one quotient bit per
// cycle, and last the output load that registers its result; load, restart
// and unused commands pass only through execute and the output load. The next
// input beat can be accepted in the cycle after the result is registered.
// The result sits in an output register, so a new input beat is accepted
// while an earlier result still waits on the master side. Table entries are
// not cleared by reset and must be loaded before a draw reads them.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_data (0 lower_bound, 1 upper_bound, 2 table_length, 3 initial_seed)
// and should only be written while the unit is idle.
module table_driven_random_draw_top (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // entry_index [7:0], entry_value [39:8]
    input  logic [1:0]  s_axis_tuser,   // command [1:0]

    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // random_value [31:0]
    output logic        m_axis_tuser    // range_error [0]
);

    // Command and status bundles between the sequencer and the datapath.
    tdrd_pkg::dp_cmd_t  dp_cmd;
    tdrd_pkg::dp_stat_t dp_stat;

    // The sequencer owns both handshakes and steps each beat through execute
    // and output load; draws also pass fetch, adjust and the remainder loop.
    tdrd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .stat          (dp_stat),
        .cmd           (dp_cmd)
    );

    // The datapath holds the configuration registers, the word table, the
    // seed and position, the remainder unit and the result register.
    tdrd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .out_value (m_axis_tdata),
        .out_error (m_axis_tuser)
    );

endmodule
